/* sv/rrhl_pkg.sv */
`default_nettype none
package rrhl_pkg;

   localparam int SLOT_W      = 8;
   localparam int SLOT_COUNT  = 256;
   localparam int ROUTE_W     = 6;
   localparam int STATUS_W    = 10;
   localparam int RTYPE_W     = 3;
   localparam int COUNT_W     = 32;
   localparam int METHOD_BYTES = 7;
   localparam int MCOUNT_W    = 4;
   localparam int PCOUNT_W    = 7;

   localparam logic [SLOT_W-1:0]   HASH_SEED    = 8'd5;
   localparam logic [MCOUNT_W-1:0] METHOD_LIMIT = 4'd7;
   localparam logic [MCOUNT_W-1:0] METHOD_OVER  = 4'd8;
   localparam logic [PCOUNT_W-1:0] PATH_LIMIT   = 7'd64;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET   = 8'd32;

   localparam logic [1:0] KIND_METHOD   = 2'd0;
   localparam logic [1:0] KIND_PATH     = 2'd1;
   localparam logic [1:0] KIND_LOOKUP   = 2'd2;
   localparam logic [1:0] KIND_REGISTER = 2'd3;

   localparam logic [1:0] OUT_HIT       = 2'd0;
   localparam logic [1:0] OUT_FALL      = 2'd1;
   localparam logic [1:0] OUT_INSTALLED = 2'd2;
   localparam logic [1:0] OUT_FULL      = 2'd3;

   typedef struct packed {
      logic method_en;
      logic path_en;
      logic rd_en;
      logic info_en;
      logic do_lookup;
      logic do_install;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [METHOD_BYTES-1:0][7:0] method;
      logic [STATUS_W-1:0]          status;
      logic [RTYPE_W-1:0]           rtype;
      logic [ROUTE_W-1:0]           index;
   } slot_entry_type;

endpackage
`default_nettype wire

/* sv/request_route_hash_lookup_unit.sv */
// request route hash lookup unit
// input channel req_*: one item per request byte or end marker. req_tuser holds
// the kind (method byte, path byte, end of lookup, end of route registration).
// method bytes are upper-cased, path bytes lower-cased and folded into an 8-bit
// djb2 hash that picks one of 256 table slots.
// byte items give no result; the block takes one per cycle while no end item is pending.
// an end item is accepted in a cycle that issues the table read (lookup) or captures
// the route type and status (registration); its compare or install state then loads
// the result register once that is free, and rsp_tvalid comes from that register.
// req_tready is low from the accept until the result register is loaded.
// result channel rsp_*: one item per end item, held in an output register;
// byte items are still taken while a result waits. if rsp_tready stays low the
// next end item waits in its compare or install state until the register frees up.
// reset (synchronous, active high) empties the route table at once through
// per-slot valid bits, zeroes the counters and clears the request state;
// req_tready rises in the cycle after reset is released.
`default_nettype none
module request_route_hash_lookup_unit
   import rrhl_pkg::*;
#(
   parameter int MAX_ROUTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // char_byte, route_type, route_status, zero pad
   input  wire logic [1:0]  req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // route_index, hit_status, type_out, hit_total,
                                         // fall_total, zero pad
   output logic [1:0]       rsp_tuser    // outcome
);

   cmd_type                cmd;
   status_type             status;
   logic [ROUTE_W-1:0]     route_index;
   logic [STATUS_W-1:0]    hit_status;
   logic [RTYPE_W-1:0]     type_out;
   logic [COUNT_W-1:0]     hit_total, fall_total;

   rrhl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrhl_dp #(
      .MAX_ROUTES (MAX_ROUTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .char_byte    (req_tdata[7:0]),
      .route_type   (req_tdata[10:8]),
      .route_status (req_tdata[20:11]),
      .status       (status),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .outcome      (rsp_tuser),
      .route_index  (route_index),
      .hit_status   (hit_status),
      .type_out     (type_out),
      .hit_total    (hit_total),
      .fall_total   (fall_total)
   );

   assign rsp_tdata = {5'd0, fall_total, hit_total, type_out, hit_status, route_index};

endmodule
`default_nettype wire

/* sv/rrhl_ctrl.sv */
`default_nettype none
module rrhl_ctrl
   import rrhl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic [1:0] req_kind,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_INSTALL
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      cmd            = '0;
      cmd.method_en  = accept && (req_kind == KIND_METHOD);
      cmd.path_en    = accept && (req_kind == KIND_PATH);
      cmd.rd_en      = accept && (req_kind == KIND_LOOKUP);
      cmd.info_en    = accept && (req_kind == KIND_REGISTER);
      cmd.do_lookup  = (state_ff == ST_LOOK) && status.out_free;
      cmd.do_install = (state_ff == ST_INSTALL) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               ready_ff <= 1'b1;
               if (accept && req_kind == KIND_LOOKUP) begin
                  state_ff <= ST_LOOK;
                  ready_ff <= 1'b0;
               end else if (accept && req_kind == KIND_REGISTER) begin
                  state_ff <= ST_INSTALL;
                  ready_ff <= 1'b0;
               end
            end
            ST_LOOK, ST_INSTALL: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* sv/rrhl_dp.sv */
`default_nettype none
module rrhl_dp
   import rrhl_pkg::*;
#(
   parameter int MAX_ROUTES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   input  wire logic [7:0]           char_byte,
   input  wire logic [RTYPE_W-1:0]   route_type,
   input  wire logic [STATUS_W-1:0]  route_status,
   output status_type                status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                outcome,
   output logic [ROUTE_W-1:0]        route_index,
   output logic [STATUS_W-1:0]       hit_status,
   output logic [RTYPE_W-1:0]        type_out,
   output logic [COUNT_W-1:0]        hit_total,
   output logic [COUNT_W-1:0]        fall_total
);

   localparam int RouteCntW = $clog2(MAX_ROUTES + 1);

   logic [SLOT_W-1:0]            hash_ff, hash_in;
   logic [MCOUNT_W-1:0]          mcount_ff, mcount_in;
   logic [PCOUNT_W-1:0]          pcount_ff, pcount_in;
   logic [METHOD_BYTES-1:0][7:0] method_ff, method_in;
   logic [RouteCntW-1:0]         used_ff;
   logic [COUNT_W-1:0]           hit_ff, fall_ff;
   logic [SLOT_COUNT-1:0]        valid_ff;
   slot_entry_type               slot_mem [SLOT_COUNT];
   slot_entry_type               rd_entry_ff;
   slot_entry_type               wr_entry;
   logic                         rd_valid_ff;
   logic [RTYPE_W-1:0]           new_type_ff;
   logic [STATUS_W-1:0]          new_status_ff;
   logic                         rsp_valid_ff;
   logic [1:0]                   outcome_ff;
   logic [ROUTE_W-1:0]           index_ff;
   logic [STATUS_W-1:0]          status_ff;
   logic [RTYPE_W-1:0]           type_ff;
   logic [7:0]                   upper_c, lower_c, fold_c;
   logic                         table_full, is_hit, install_en;

   assign upper_c = (char_byte >= ASCII_LOWER_A && char_byte <= ASCII_LOWER_Z)
                    ? char_byte - CASE_OFFSET : char_byte;
   assign lower_c = (char_byte >= ASCII_UPPER_A && char_byte <= ASCII_UPPER_Z)
                    ? char_byte + CASE_OFFSET : char_byte;

   assign table_full = used_ff >= RouteCntW'(MAX_ROUTES);
   assign install_en = cmd.do_install && !table_full;
   assign is_hit     = rd_valid_ff && (rd_entry_ff.method == method_ff)
                       && (mcount_ff != '0) && (mcount_ff <= METHOD_LIMIT)
                       && (pcount_ff != '0);

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_entry        = '0;
      wr_entry.method = method_ff;
      wr_entry.status = new_status_ff;
      wr_entry.rtype  = new_type_ff;
      wr_entry.index  = ROUTE_W'(used_ff);
   end

   always_comb begin
      hash_in   = hash_ff;
      mcount_in = mcount_ff;
      pcount_in = pcount_ff;
      method_in = method_ff;
      fold_c    = cmd.method_en ? upper_c : lower_c;
      if (cmd.method_en) begin
         if (mcount_ff < METHOD_LIMIT) begin
            hash_in = (hash_ff << 5) + hash_ff + fold_c;
            method_in[mcount_ff[2:0]] = upper_c;
            mcount_in = mcount_ff + 4'd1;
         end else begin
            mcount_in = METHOD_OVER;
         end
      end else if (cmd.path_en) begin
         if (pcount_ff < PATH_LIMIT) begin
            hash_in   = (hash_ff << 5) + hash_ff + fold_c;
            pcount_in = pcount_ff + 7'd1;
         end
      end else if (cmd.do_lookup || cmd.do_install) begin
         hash_in   = HASH_SEED;
         mcount_in = '0;
         pcount_in = '0;
         method_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= HASH_SEED;
         mcount_ff    <= '0;
         pcount_ff    <= '0;
         method_ff    <= '0;
         used_ff      <= '0;
         hit_ff       <= '0;
         fall_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff   <= hash_in;
         mcount_ff <= mcount_in;
         pcount_ff <= pcount_in;
         method_ff <= method_in;
         if (cmd.do_lookup) begin
            if (is_hit) begin
               hit_ff <= hit_ff + 32'd1;
            end else begin
               fall_ff <= fall_ff + 32'd1;
            end
         end
         if (install_en) begin
            used_ff           <= used_ff + 1'b1;
            valid_ff[hash_ff] <= 1'b1;
         end
         if (cmd.do_lookup || cmd.do_install) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (install_en) begin
         slot_mem[hash_ff] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= slot_mem[hash_ff];
         rd_valid_ff <= valid_ff[hash_ff];
      end
      if (cmd.info_en) begin
         new_type_ff   <= route_type;
         new_status_ff <= route_status;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_lookup) begin
         if (is_hit) begin
            outcome_ff <= OUT_HIT;
            index_ff   <= rd_entry_ff.index;
            status_ff  <= rd_entry_ff.status;
            type_ff    <= rd_entry_ff.rtype;
         end else begin
            outcome_ff <= OUT_FALL;
            index_ff   <= '0;
            status_ff  <= '0;
            type_ff    <= '0;
         end
      end else if (cmd.do_install) begin
         outcome_ff <= table_full ? OUT_FULL : OUT_INSTALLED;
         index_ff   <= table_full ? '0 : ROUTE_W'(used_ff);
         status_ff  <= '0;
         type_ff    <= '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign outcome     = outcome_ff;
   assign route_index = index_ff;
   assign hit_status  = status_ff;
   assign type_out    = type_ff;
   assign hit_total   = hit_ff;
   assign fall_total  = fall_ff;

endmodule
`default_nettype wire

/* sv/rrhl_chk.sv */
`default_nettype none
module rrhl_chk
   import rrhl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("output or ready not cleared by reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_LOOKUP || req_tuser == KIND_REGISTER)
      |=> !req_tready)
      else $error("input taken during end item processing");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OUT_HIT |-> rsp_tdata[18:6] == '0)
      else $error("status or type set on a non-hit result");

endmodule

bind request_route_hash_lookup_unit rrhl_chk u_rrhl_chk (.*);
`default_nettype wire
